// ===== hdl/aes256_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-256 package
// Shared types, constants and byte-level functions for the AES-256 core.
// ----------------------------------------------------------------------------
package aes256_pkg;

  localparam int unsigned KEY_WORDS = 8;
  localparam int unsigned NUM_KEY_REGS = 4;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_DERIVE,
    ST_ROUND,
    ST_DONE
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Column in little-endian order: byte 0 in bits 7:0.
  function automatic logic [31:0] mix_word(input logic [31:0] w, input logic inv);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    logic [7:0] m9_0, m9_1, m9_2, m9_3, mb0, mb1, mb2, mb3;
    logic [7:0] md0, md1, md2, md3, me0, me1, me2, me3;
    a0 = w[7:0]; a1 = w[15:8]; a2 = w[23:16]; a3 = w[31:24];
    x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
    y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
    z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
    m9_0 = z0 ^ a0; m9_1 = z1 ^ a1; m9_2 = z2 ^ a2; m9_3 = z3 ^ a3;
    mb0 = m9_0 ^ x0; mb1 = m9_1 ^ x1; mb2 = m9_2 ^ x2; mb3 = m9_3 ^ x3;
    md0 = m9_0 ^ y0; md1 = m9_1 ^ y1; md2 = m9_2 ^ y2; md3 = m9_3 ^ y3;
    me0 = z0 ^ y0 ^ x0; me1 = z1 ^ y1 ^ x1; me2 = z2 ^ y2 ^ x2; me3 = z3 ^ y3 ^ x3;
    if (inv) begin
      mix_word = {mb0 ^ md1 ^ m9_2 ^ me3, md0 ^ m9_1 ^ me2 ^ mb3,
                  m9_0 ^ me1 ^ mb2 ^ md3, me0 ^ mb1 ^ md2 ^ m9_3};
    end else begin
      mix_word = {x0 ^ a0 ^ a1 ^ a2 ^ x3, a0 ^ a1 ^ x2 ^ x3 ^ a3,
                  a0 ^ x1 ^ x2 ^ a2 ^ a3, x0 ^ x1 ^ a1 ^ a2 ^ a3};
    end
  endfunction

endpackage

// ===== hdl/aes256_stream_if.sv =====
// ----------------------------------------------------------------------------
// AES-256 stream interfaces
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
interface aes256_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] block_low;
  logic [63:0] block_high;
  modport source (output valid, operation, block_low, block_high, input ready);
  modport sink (input valid, operation, block_low, block_high, output ready);
endinterface

interface aes256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;
  modport source (output valid, result_low, result_high, input ready);
  modport sink (input valid, result_low, result_high, output ready);
endinterface

// ===== hdl/aes256_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-256 block cipher
// Iterative AES-256 core with one shared round unit and a round-key memory.
// ----------------------------------------------------------------------------
// Usage: the key is written through cfg_we/cfg_index/cfg_data while the core
// is idle (index 0..3 hold key bytes 0..7 .. 24..31). Each input item carries
// one block and an operation bit (0 encrypt, 1 decrypt); each gives one
// result item on the output channel.
// Each item passes through the shared round unit (the initial key add and
// 14 rounds, one per cycle) and is then registered for presentation. The
// round-key memory has one read port, read one round ahead.
// After a key write, the next item first runs the key schedule: the 60
// encryption words are expanded, then the decryption words are derived
// (one word per cycle, gathered into rows for the single memory write
// port); that item is taken only once the schedule is done.
// Reset clears the key and marks the schedule stale. A stalled receiver
// holds the result in the output register; no new item is taken until the
// result has been accepted.
// ----------------------------------------------------------------------------
module aes256_block_cipher #(
  parameter int unsigned NUM_ROUNDS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [aes256_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [aes256_pkg::CFG_DATA_W-1:0]     cfg_data,
  aes256_in_if.sink                             in_ch,
  aes256_out_if.source                          out_ch
);

  localparam int unsigned RK_WORDS = 4 * (NUM_ROUNDS + 1);
  localparam int unsigned RK_AW = $clog2(2 * (NUM_ROUNDS + 1));
  localparam int unsigned WORD_W = $clog2(RK_WORDS + 1);
  localparam int unsigned RND_W = $clog2(NUM_ROUNDS + 2);

  aes256_pkg::state_t state, state_next;

  logic [63:0] key_regs [aes256_pkg::NUM_KEY_REGS];
  logic        keys_valid;

  // Encrypt round keys in rows 0..NUM_ROUNDS, decrypt round keys in rows NUM_ROUNDS+1 onward.
  logic [127:0] rk_mem [RK_WORDS / 4 * 2];
  logic [127:0] rk_rd;
  logic [31:0]  win [8];       // sliding window of the last eight words
  logic [WORD_W-1:0] widx;     // word counter for expand and derive
  logic [7:0]   rcon;
  logic [127:0] quad;          // words collected before a row write
  logic [RND_W-1:0] rnd;
  logic         decrypt;
  logic [127:0] st;
  logic [127:0] res;
  logic         res_valid;

  // Key schedule word computation.
  logic [31:0] t_word, new_word;
  always_comb begin
    t_word = win[7];
    if (widx[2:0] == 3'd0) begin
      t_word = aes256_pkg::sub_word({t_word[7:0], t_word[31:8]}) ^ {24'd0, rcon};
    end else if (widx[2:0] == 3'd4) begin
      t_word = aes256_pkg::sub_word(t_word);
    end
    new_word = win[0] ^ t_word;
  end

  // Derive: widx walks output words; reads row (NUM_ROUNDS - r) of encrypt keys.
  logic [RND_W-1:0] drow;
  logic [31:0] dsel, dword;
  always_comb begin
    drow = (widx[WORD_W-1:2] != '0) ? RND_W'(widx[WORD_W-1:2] - 1'b1) : '0;
    unique case (widx[1:0])
      2'd0: dsel = rk_rd[31:0];
      2'd1: dsel = rk_rd[63:32];
      2'd2: dsel = rk_rd[95:64];
      default: dsel = rk_rd[127:96];
    endcase
    if (drow == '0 || drow == RND_W'(NUM_ROUNDS)) dword = dsel;
    else dword = aes256_pkg::mix_word(dsel, 1'b1);
  end

  // Shared round unit.
  logic [127:0] sub_st, mix_st, rnd_out;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [1:0] src;
        src = decrypt ? 2'(c - r) : 2'(c + r);
        sub_st[8*(r+4*c) +: 8] = decrypt ? aes256_pkg::INV_SBOX[st[8*(r+4*src) +: 8]]
                                         : aes256_pkg::SBOX[st[8*(r+4*src) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mix_st[32*c +: 32] = aes256_pkg::mix_word(sub_st[32*c +: 32], decrypt);
    end
    rnd_out = ((rnd == RND_W'(NUM_ROUNDS)) ? sub_st : mix_st) ^ rk_rd;
  end

  // Row needed for the next word while deriving, since the memory read is registered.
  function automatic logic [RND_W-1:0] drow_ahead();
    logic [WORD_W-1:0] nxt;
    nxt = widx + 1'b1;
    drow_ahead = RND_W'(nxt[WORD_W-1:2] - 1'b1);
  endfunction

  // Memory read address, registered read.
  logic [RK_AW-1:0] rd_addr;
  always_comb begin
    rd_addr = '0;
    unique case (state)
      aes256_pkg::ST_DERIVE: rd_addr = RK_AW'(NUM_ROUNDS) - RK_AW'(drow_ahead());
      aes256_pkg::ST_ROUND: rd_addr = RK_AW'(rnd) + RK_AW'(1)
                                      + (decrypt ? RK_AW'(NUM_ROUNDS + 1) : '0);
      default: rd_addr = in_ch.operation ? RK_AW'(NUM_ROUNDS + 1) : '0;
    endcase
  end

  logic        mem_we;
  logic [RK_AW-1:0] wr_addr;
  logic [127:0] wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) rk_mem[wr_addr] <= wr_data;
    rk_rd <= rk_mem[rd_addr];
  end

  logic in_fire, out_fire, start_ok;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign start_ok = state == aes256_pkg::ST_IDLE && !res_valid;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      aes256_pkg::ST_IDLE: begin
        if (in_ch.valid && start_ok) begin
          state_next = keys_valid ? aes256_pkg::ST_ROUND : aes256_pkg::ST_EXPAND;
        end
      end
      aes256_pkg::ST_EXPAND: begin
        if (widx == WORD_W'(RK_WORDS - 1)) state_next = aes256_pkg::ST_DERIVE;
      end
      aes256_pkg::ST_DERIVE: begin
        if (widx == WORD_W'(RK_WORDS + 3)) state_next = aes256_pkg::ST_IDLE;
      end
      aes256_pkg::ST_ROUND: begin
        if (rnd == RND_W'(NUM_ROUNDS)) state_next = aes256_pkg::ST_DONE;
      end
      default: state_next = aes256_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready = start_ok && keys_valid;
    mem_we  = 1'b0;
    wr_addr = '0;
    wr_data = quad;
    unique case (state)
      aes256_pkg::ST_EXPAND: begin
        mem_we  = widx[1:0] == 2'd3;
        wr_addr = RK_AW'(widx[WORD_W-1:2]);
        // The first two rows are the key words themselves.
        wr_data = {(widx < WORD_W'(aes256_pkg::KEY_WORDS)) ? win[widx[2:0]] : new_word,
                   quad[127:32]};
      end
      aes256_pkg::ST_DERIVE: begin
        // Derived words lag the read by one row; written on the last of four.
        mem_we  = widx[1:0] == 2'd3 && widx >= WORD_W'(7);
        wr_addr = RK_AW'(NUM_ROUNDS + 1) + RK_AW'(drow);
        wr_data = {dword, quad[127:32]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= aes256_pkg::ST_IDLE;
      keys_valid <= 1'b0;
      res_valid  <= 1'b0;
      for (int i = 0; i < aes256_pkg::NUM_KEY_REGS; i++) key_regs[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        key_regs[cfg_index] <= cfg_data;
        keys_valid <= 1'b0;
      end
      if (state == aes256_pkg::ST_DERIVE && state_next == aes256_pkg::ST_IDLE) begin
        keys_valid <= 1'b1;
      end
      if (state == aes256_pkg::ST_DONE) res_valid <= 1'b1;
      else if (out_fire) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      aes256_pkg::ST_IDLE: begin
        widx <= '0;
        rcon <= 8'h01;
        for (int i = 0; i < 8; i++) begin
          win[i] <= key_regs[i / 2][32*(i%2) +: 32];
        end
        if (in_fire) begin
          st      <= {in_ch.block_high, in_ch.block_low};
          decrypt <= in_ch.operation == aes256_pkg::OP_DECRYPT;
          rnd     <= '0;
        end
      end
      aes256_pkg::ST_EXPAND: begin
        // The first eight words are the key itself.
        if (widx < WORD_W'(aes256_pkg::KEY_WORDS)) begin
          quad <= {win[widx[2:0]], quad[127:32]};
        end else begin
          quad <= {new_word, quad[127:32]};
          for (int i = 0; i < 7; i++) win[i] <= win[i+1];
          win[7] <= new_word;
          if (widx[2:0] == 3'd0) rcon <= aes256_pkg::xtime(rcon);
        end
        widx <= (widx == WORD_W'(RK_WORDS - 1)) ? '0 : widx + 1'b1;
      end
      aes256_pkg::ST_DERIVE: begin
        if (widx >= WORD_W'(4)) quad <= {dword, quad[127:32]};
        widx <= widx + 1'b1;
      end
      aes256_pkg::ST_ROUND: begin
        st  <= (rnd == '0) ? st ^ rk_rd : rnd_out;
        rnd <= rnd + 1'b1;
      end
      aes256_pkg::ST_DONE: res <= st;
      default: ;
    endcase
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.result_low  = res[63:0];
  assign out_ch.result_high = res[127:64];

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == aes256_pkg::ST_ROUND) else $error("item taken while busy");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_ch.ready |=> res_valid && $stable(res)) else $error("result lost");
  a_keys_before_use: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> keys_valid) else $error("item taken with stale keys");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-256 block cipher testbench
// Drives blocks through the cipher under several keys, predicts every result
// with a behavioral AES-256 built here, and checks each result in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [1:0] {
    KEY_BYTES_0_7,
    KEY_BYTES_8_15,
    KEY_BYTES_16_23,
    KEY_BYTES_24_31
  } key_reg_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } block_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  aes256_in_if  in_ch ();
  aes256_out_if out_ch ();

  aes256_block_cipher i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [7:0]  fwd_sub [256];
  logic [7:0]  rev_sub [256];
  logic [63:0] key_copy [4];
  logic [31:0] enc_words [60];
  logic [31:0] dec_words [60];
  bit          schedule_fresh;
  block_t      pending_results [$];
  int          errors;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // The substitution tables are derived from the field inverse and the affine map.
  function automatic void build_sub_tables();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sub[x] = s;
      rev_sub[s] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = fwd_sub[w[8*k +: 8]];
    return r;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w, input bit inv);
    logic [7:0] coef [4];
    logic [31:0] r;
    if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    r = '0;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) r[8*k +: 8] ^= gf_mul(w[8*j +: 8], coef[(j - k) & 3]);
    end
    return r;
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0] rcon;
    rcon = 8'h01;
    for (int i = 0; i < 8; i++) enc_words[i] = 32'(key_copy[i >> 1] >> (32 * (i & 1)));
    for (int i = 8; i < 60; i++) begin
      t = enc_words[i - 1];
      if (i % 8 == 0) begin
        t = sub_bytes32({t[7:0], t[31:8]}) ^ {24'h0, rcon};
        rcon = gf_mul(rcon, 8'h02);
      end else if (i % 8 == 4) begin
        t = sub_bytes32(t);
      end
      enc_words[i] = enc_words[i - 8] ^ t;
    end
    // Equivalent inverse cipher: reversed round order, middle keys unmixed.
    for (int r = 0; r <= 14; r++) begin
      for (int j = 0; j < 4; j++) begin
        t = enc_words[4 * (14 - r) + j];
        if (r != 0 && r != 14) t = mix_col(t, 1'b1);
        dec_words[4 * r + j] = t;
      end
    end
    schedule_fresh = 1'b1;
  endfunction

  function automatic logic [127:0] cipher_block(input logic op, input logic [127:0] blk);
    logic [127:0] s, t;
    bit dec;
    int src;
    dec = (op == aes256_pkg::OP_DECRYPT);
    if (!schedule_fresh) expand_schedule();
    s = blk;
    for (int r = 0; r <= 14; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++) begin
          for (int row = 0; row < 4; row++) begin
            src = dec ? ((c + 4 - row) & 3) : ((c + row) & 3);
            t[8*(row + 4*c) +: 8] = dec ? rev_sub[s[8*(row + 4*src) +: 8]]
                                        : fwd_sub[s[8*(row + 4*src) +: 8]];
          end
        end
        if (r != 14) begin
          for (int c = 0; c < 4; c++) t[32*c +: 32] = mix_col(t[32*c +: 32], dec);
        end
        s = t;
      end
      for (int c = 0; c < 4; c++) s[32*c +: 32] ^= dec ? dec_words[4*r + c] : enc_words[4*r + c];
    end
    return s;
  endfunction

  task automatic write_key(input key_reg_t idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    key_copy[idx] = value;
    schedule_fresh = 1'b0;
  endtask

  task automatic write_all_keys(input logic [255:0] key);
    write_key(KEY_BYTES_0_7, key[63:0]);
    write_key(KEY_BYTES_8_15, key[127:64]);
    write_key(KEY_BYTES_16_23, key[191:128]);
    write_key(KEY_BYTES_24_31, key[255:192]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one item; called and returns at a rising edge, leaving valid high.
  task automatic send_block(input logic op, input logic [63:0] lo, input logic [63:0] hi);
    logic rdy;
    block_t exp_blk;
    logic [127:0] res;
    if (!quiet && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.block_low <= lo;
    in_ch.block_high <= hi;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    res = cipher_block(op, {hi, lo});
    exp_blk.lo = res[63:0];
    exp_blk.hi = res[127:64];
    pending_results.push_back(exp_blk);
  endtask

  // Drops valid, waits until every result is back, then idles before returning.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_key();
    send_block(aes256_pkg::OP_ENCRYPT, '0, '0);
    send_block(aes256_pkg::OP_DECRYPT, '0, '0);
    send_block(aes256_pkg::OP_ENCRYPT, '1, '1);
    send_block(aes256_pkg::OP_DECRYPT, '1, '1);
    drain();
  endtask

  task automatic test_standard_vector();
    write_all_keys(256'h1f1e1d1c1b1a191817161514131211100f0e0d0c0b0a09080706050403020100);
    send_block(aes256_pkg::OP_ENCRYPT, 64'h7766554433221100, 64'hffeeddccbbaa9988);
    send_block(aes256_pkg::OP_DECRYPT, 64'hbf456751cab7a28e, 64'h8960494b9049fcea);
    send_block(aes256_pkg::OP_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(aes256_pkg::OP_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_block(aes256_pkg::OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    drain();
  endtask

  task automatic test_key_extremes();
    write_all_keys('1);
    send_block(aes256_pkg::OP_ENCRYPT, '0, '1);
    send_block(aes256_pkg::OP_DECRYPT, '1, '0);
    drain();
    write_all_keys('0);
    send_block(aes256_pkg::OP_ENCRYPT, '1, '0);
    send_block(aes256_pkg::OP_DECRYPT, '0, '1);
    drain();
  endtask

  // A single register changed between items must still trigger a new schedule.
  task automatic test_partial_rekey();
    key_reg_t idx;
    for (int i = 0; i < 4; i++) begin
      idx = key_reg_t'(i);
      write_key(idx, rand64());
      cfg_we <= 1'b0;
      @(posedge clk);
      send_block(aes256_pkg::OP_ENCRYPT, rand64(), rand64());
      send_block(aes256_pkg::OP_DECRYPT, rand64(), rand64());
      drain();
    end
    // Rewriting the same value also invalidates the schedule.
    write_key(KEY_BYTES_8_15, key_copy[KEY_BYTES_8_15]);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_block(aes256_pkg::OP_ENCRYPT, rand64(), rand64());
    drain();
  endtask

  task automatic test_random_traffic();
    logic [127:0] blk;
    for (int phase = 0; phase < 10; phase++) begin
      write_all_keys({rand64(), rand64(), rand64(), rand64()});
      quiet = (phase == 4);
      for (int n = 0; n < 68; n++) begin
        blk = {rand64(), rand64()};
        // Decrypting the most recent expected result, which may be of an encryption, exercises the round trip.
        if (n % 5 == 4 && pending_results.size() != 0) begin
          blk = {pending_results[$].hi, pending_results[$].lo};
          send_block(aes256_pkg::OP_DECRYPT, blk[63:0], blk[127:64]);
        end else begin
          send_block($urandom_range(1) ? aes256_pkg::OP_DECRYPT : aes256_pkg::OP_ENCRYPT,
                     blk[63:0], blk[127:64]);
        end
      end
      quiet = 1'b0;
      drain();
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= (!quiet && $urandom_range(99) < 6) ? 1'b0 : 1'b1;
  end

  always @(negedge clk) begin
    block_t exp_blk;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result low %h high %h", $time,
                 out_ch.result_low, out_ch.result_high);
        errors++;
      end else begin
        exp_blk = pending_results.pop_front();
        if (out_ch.result_low !== exp_blk.lo) begin
          $display("%0t: result_low expected %h actual %h", $time, exp_blk.lo,
                   out_ch.result_low);
          errors++;
        end
        if (out_ch.result_high !== exp_blk.hi) begin
          $display("%0t: result_high expected %h actual %h", $time, exp_blk.hi,
                   out_ch.result_high);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = aes256_pkg::OP_ENCRYPT;
    in_ch.block_low = '0;
    in_ch.block_high = '0;
    errors = 0;
    quiet = 1'b0;
    for (int i = 0; i < 4; i++) key_copy[i] = '0;
    schedule_fresh = 1'b0;
    build_sub_tables();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_standard_vector();
    test_key_extremes();
    test_partial_rekey();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
